>>> hdl/sasp_pkg.sv
// Shared types and constants for the sliding absolute-sum peak finder.
package sasp_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int START_W  = 16;
    localparam int BSUM_W   = 26;
    localparam int WLEN_W   = 11;

    // APB register map: one 32-bit register per word
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Result stream tdata: best_start, best_sum, padded to whole bytes
    localparam int M_TDATA_W = 48;

    typedef enum logic [0:0] {
        REG_WINDOW_LEN = 1'b0
    } t_reg_idx;

    // Per-sample information handed from the address stage to the sum stage
    typedef struct packed {
        logic                last;
        logic                in_range;
        logic                sub;
        logic                cmp;
        logic [SAMPLE_W-1:0] mag;
        logic [START_W-1:0]  start;
    } t_s1_info;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] best_start;
        logic [BSUM_W-1:0]  best_sum;
    } t_result;

endpackage

>>> hdl/sasp_ram.sv
// Generic simple dual-port RAM, read-first, registered read data.
module sasp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sliding_abs_sum_peak_finder.sv
// Top level of the sliding-window absolute-sum peak finder.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+----------------------------------------
//  s stream  | in        | tvalid/tready       | tdata[15:0] sample, tlast = last
//  m stream  | out       | tvalid/tready       | tdata best_start/best_sum, tuser found
//  apb       | in        | psel/penable/pready | reg 0 @ 0x0: window_len[10:0]
//
// One sample beat per cycle while o_s_tready is high. Each beat passes the address
// stage, which reads the ring entry that leaves the window and writes the new magnitude
// into the delay RAM, then the sum stage, which gets the RAM read data and updates the
// running sum and the peak. A beat with tlast pushes its result into the output queue.
// Results wait in a two-entry output queue; o_s_tready drops only when that queue
// could overflow. Reset is synchronous; the delay RAM needs no clearing pass.
module sliding_abs_sum_peak_finder
    import sasp_pkg::*;
#(
    parameter int MAX_WINDOW = 1024,
    parameter int MAX_FRAME  = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [SAMPLE_W-1:0]   i_s_tdata,   // [15:0] sample
    input  logic                  i_s_tlast,

    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [15:0] best_start, [41:16] best_sum, zeros
    output logic                  o_m_tuser,   // [0] found

    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_AW-1:0]     i_paddr,
    input  logic [APB_DW-1:0]     i_pwdata,
    output logic [APB_DW-1:0]     o_prdata,
    output logic                  o_pready
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int SW = $clog2(MAX_WINDOW) + SAMPLE_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [WLEN_W-1:0] r_window_len;
    logic              cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite & o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WLEN_W'(1);
        end else if (cfg_wr) begin
            case (t_reg_idx'(i_paddr[2]))
                REG_WINDOW_LEN: r_window_len <= i_pwdata[WLEN_W-1:0];
                default:        r_window_len <= r_window_len;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(i_paddr[2]))
            REG_WINDOW_LEN: o_prdata = APB_DW'(r_window_len);
            default:        o_prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Address stage: frame counters, ring pointer, delay RAM access
    // ------------------------------------------------------------------
    logic [AW-1:0]       r_wp;
    logic [CW-1:0]       r_count;
    logic [WW-1:0]       r_frame_w;

    logic                s_accept;
    logic                in_range;
    logic [31:0]         wl32;
    logic [WW-1:0]       w_clamp;
    logic [WW-1:0]       w_eff;
    logic [31:0]         w32;
    logic [31:0]         wp32;
    logic [31:0]         old32;
    logic [CW-1:0]       cnt_inc;
    logic [AW-1:0]       wp_next;
    logic [SAMPLE_W-1:0] mag;
    logic [SAMPLE_W-1:0] ram_rdata;
    t_s1_info            s0_info;

    assign s_accept = i_s_tvalid & o_s_tready;
    assign in_range = 32'(r_count) < 32'(MAX_FRAME);

    // Clamp window_len to 1..MAX_WINDOW
    always_comb begin
        wl32 = 32'(r_window_len);
        if (wl32 == 32'd0) begin
            w_clamp = WW'(1);
        end else if (wl32 > 32'(MAX_WINDOW)) begin
            w_clamp = WW'(MAX_WINDOW);
        end else begin
            w_clamp = WW'(wl32);
        end
    end

    // The frame's window length is latched on its first sample
    assign w_eff   = (r_count == '0) ? w_clamp : r_frame_w;
    assign w32     = 32'(w_eff);
    assign wp32    = 32'(r_wp);
    assign old32   = (wp32 >= w32) ? (wp32 - w32) : (wp32 + 32'(MAX_WINDOW) - w32);
    assign cnt_inc = r_count + 1'b1;
    assign wp_next = (wp32 == 32'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;

    // Two's-complement magnitude; -32768 maps to 32768
    assign mag = i_s_tdata[SAMPLE_W-1] ? (~i_s_tdata + 1'b1) : i_s_tdata;

    always_comb begin
        s0_info.last     = i_s_tlast;
        s0_info.in_range = in_range;
        s0_info.sub      = 32'(r_count) >= w32;
        s0_info.cmp      = in_range && (32'(cnt_inc) >= w32);
        s0_info.mag      = mag;
        s0_info.start    = START_W'(32'(cnt_inc) - w32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_count   <= '0;
            r_frame_w <= WW'(1);
        end else if (s_accept) begin
            if (in_range && (r_count == '0)) begin
                r_frame_w <= w_eff;
            end
            if (i_s_tlast) begin
                // end of frame: rewind the ring and count
                r_wp    <= '0;
                r_count <= '0;
            end else if (in_range) begin
                r_wp    <= wp_next;
                r_count <= cnt_inc;
            end
        end
    end

    // Read-first RAM: with a full-depth window the entry read and written is the same
    // one, and the old magnitude is what leaves the window.
    sasp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_delay (
        .i_clk   (i_clk),
        .i_we    (s_accept & in_range),
        .i_waddr (r_wp),
        .i_wdata (mag),
        .i_raddr (AW'(old32)),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sum stage: running sum, peak tracking, result build
    // ------------------------------------------------------------------
    logic               r_s1_valid;
    t_s1_info           r_s1;
    logic [SW-1:0]      r_sum;
    logic [SW-1:0]      r_peak_sum;
    logic [START_W-1:0] r_peak_start;
    logic               r_have_peak;

    logic [SW-1:0]      n_sum;
    logic [SW-1:0]      n_peak_sum;
    logic [START_W-1:0] n_peak_start;
    logic               n_have_peak;
    logic               take;
    t_result            res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= s_accept;
        end
        r_s1 <= s0_info;
    end

    always_comb begin
        n_sum = r_sum;
        if (r_s1_valid && r_s1.in_range) begin
            n_sum = r_sum - (r_s1.sub ? SW'(ram_rdata) : '0) + SW'(r_s1.mag);
        end
        // strict compare keeps the earlier window on a tie
        take = r_s1_valid && r_s1.cmp && (!r_have_peak || (n_sum > r_peak_sum));
        n_peak_sum   = take ? n_sum : r_peak_sum;
        n_peak_start = take ? r_s1.start : r_peak_start;
        n_have_peak  = r_have_peak | take;

        res.found      = n_have_peak;
        res.best_start = n_have_peak ? n_peak_start : '0;
        if (!n_have_peak) begin
            res.best_sum = '0;
        end else if (64'(n_peak_sum) > 64'(2**BSUM_W - 1)) begin
            res.best_sum = '1;
        end else begin
            res.best_sum = BSUM_W'(64'(n_peak_sum));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_peak_sum   <= '0;
            r_peak_start <= '0;
            r_have_peak  <= 1'b0;
        end else if (r_s1_valid && r_s1.last) begin
            // clear for the next frame
            r_sum        <= '0;
            r_peak_sum   <= '0;
            r_peak_start <= '0;
            r_have_peak  <= 1'b0;
        end else begin
            r_sum        <= n_sum;
            r_peak_sum   <= n_peak_sum;
            r_peak_start <= n_peak_start;
            r_have_peak  <= n_have_peak;
        end
    end

    // ------------------------------------------------------------------
    // Output queue: head register plus one holding slot
    // ------------------------------------------------------------------
    logic    r_out_valid;
    logic    r_hold_valid;
    t_result r_out;
    t_result r_hold;
    logic    n_out_valid;
    logic    n_hold_valid;
    t_result n_out;
    t_result n_hold;
    logic    pop;
    logic    push;

    assign pop  = r_out_valid & i_m_tready;
    assign push = r_s1_valid & r_s1.last;

    // Stall input when both slots are taken after this edge: a beat accepted now
    // can end a frame in the sum stage next cycle.
    assign o_s_tready = !n_hold_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_hold       = r_hold;
        if (pop) begin
            n_out_valid  = r_hold_valid;
            n_out        = r_hold;
            n_hold_valid = 1'b0;
        end
        if (push) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = res;
            end else begin
                n_hold_valid = 1'b1;
                n_hold       = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.found;
    assign o_m_tdata  = M_TDATA_W'({r_out.best_sum, r_out.best_start});

endmodule

>>> hdl/sasp_chk.sv
// Port-level checker for the peak finder, bound to the top level.
module sasp_chk
    import sasp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  o_s_tready,
    input  logic                  i_s_tlast,
    input  logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  o_m_tdata,
    input  logic                  o_m_tuser
);

    logic last_beat;
    assign last_beat = i_s_tvalid & o_s_tready & i_s_tlast;

    // Drop the result stream right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // A new result appears only after a last beat has passed the sum stage
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(last_beat, 2))
        else $error("result without a last beat");

    // No window found means start and sum read zero
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("nonzero payload on empty result");

    // Hold a stalled result
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                          && $stable(o_m_tuser)))
        else $error("stalled result changed");

endmodule

bind sliding_abs_sum_peak_finder sasp_chk u_sasp_chk (.*);

>>> verif/sasp_peak_check.sv
// Scoreboard for the sliding absolute-sum peak finder: tracks windows and checks results.
module sasp_peak_check
    import sasp_pkg::*;
#(
    parameter int MAX_WINDOW = 1024,
    parameter int MAX_FRAME  = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [SAMPLE_W-1:0]  i_s_tdata,   // [15:0] sample
    input  logic                 i_s_tlast,

    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // [15:0] best_start, [41:16] best_sum, zeros
    input  logic                 i_m_tuser,   // [0] found

    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [APB_AW-1:0]    i_paddr,
    input  logic [APB_DW-1:0]    i_pwdata,
    input  logic [APB_DW-1:0]    i_prdata,
    input  logic                 i_pready,

    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [APB_AW-1:0] WLEN_ADDR = APB_AW'(4 * REG_WINDOW_LEN);
    localparam longint unsigned   SUM_MAX   = (64'd1 << BSUM_W) - 1;

    // Shadow of the window state
    logic [SAMPLE_W-1:0] abs_ring [MAX_WINDOW];
    int unsigned         wr_ptr;
    longint unsigned     run_sum;
    int unsigned         seen;
    longint unsigned     peak_sum;
    int unsigned         peak_start;
    logic                have_peak;
    logic [WLEN_W-1:0]   cfg_wlen;
    int unsigned         frame_wlen;

    t_result peaks_due [$];
    int      mismatches = 0;
    int      due_count  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = due_count;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t peak check: %s got %0d want %0d", $time, what, got, want);
    endtask

    // Fold one sample into the window sum; queue the frame's peak on its final sample.
    task automatic track_window_peak(input logic [SAMPLE_W-1:0] raw, input logic fin);
        logic [SAMPLE_W-1:0] mag;
        int unsigned         w;
        int unsigned         old_idx;
        t_result             r;
        mag = raw[SAMPLE_W-1] ? SAMPLE_W'(~raw + 1'b1) : raw;
        if (seen < MAX_FRAME) begin
            if (seen == 0)
                frame_wlen = (cfg_wlen == 0) ? 1 :
                             (cfg_wlen > MAX_WINDOW) ? MAX_WINDOW : cfg_wlen;
            w = frame_wlen;
            old_idx = (wr_ptr + MAX_WINDOW - w) % MAX_WINDOW;
            if (seen >= w)
                run_sum -= abs_ring[old_idx];
            abs_ring[wr_ptr] = mag;
            run_sum += mag;
            wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
            seen++;
            // strict compare keeps the earlier window on a tie
            if (seen >= w && (!have_peak || run_sum > peak_sum)) begin
                have_peak  = 1'b1;
                peak_sum   = run_sum;
                peak_start = seen - w;
            end
        end
        if (fin) begin
            r.found      = have_peak;
            r.best_start = START_W'(peak_start);
            r.best_sum   = (peak_sum > SUM_MAX) ? '1 : BSUM_W'(peak_sum);
            peaks_due.push_back(r);
            wr_ptr     = 0;
            run_sum    = 0;
            seen       = 0;
            peak_sum   = 0;
            peak_start = 0;
            have_peak  = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            wr_ptr     = 0;
            run_sum    = 0;
            seen       = 0;
            peak_sum   = 0;
            peak_start = 0;
            have_peak  = 1'b0;
            cfg_wlen   = 1;
            frame_wlen = 1;
            peaks_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == WLEN_ADDR) begin
                if (i_pwrite)
                    cfg_wlen = i_pwdata[WLEN_W-1:0];
                else if (i_prdata != APB_DW'(cfg_wlen))
                    report_mismatch("window_len readback", i_prdata, cfg_wlen);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.found      = i_m_tuser;
                got.best_start = i_m_tdata[START_W-1:0];
                got.best_sum   = i_m_tdata[START_W +: BSUM_W];
                if (peaks_due.size() == 0) begin
                    report_mismatch("result beat with none pending, best_sum", got.best_sum, 0);
                end else begin
                    want = peaks_due.pop_front();
                    if (got.found != want.found)
                        report_mismatch("found", got.found, want.found);
                    if (got.best_start != want.best_start)
                        report_mismatch("best_start", got.best_start, want.best_start);
                    if (got.best_sum != want.best_sum)
                        report_mismatch("best_sum", got.best_sum, want.best_sum);
                end
            end
            if (i_s_tvalid && i_s_tready)
                track_window_peak(i_s_tdata, i_s_tlast);
        end
        due_count = peaks_due.size();
    end

endmodule

>>> verif/sliding_abs_sum_peak_finder_test.sv
// Top of the peak finder testbench: clock, reset, stimulus, back-pressure and verdict.
module sliding_abs_sum_peak_finder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sasp_pkg::*;

    localparam int WIN_CAP     = 1024;
    localparam int FRAME_CAP   = 65536;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [APB_AW-1:0] WLEN_ADDR  = APB_AW'(4 * REG_WINDOW_LEN);
    // first word past the register map; writes there must be dropped
    localparam logic [APB_AW-1:0] SPARE_ADDR = APB_AW'(4 * (REG_WINDOW_LEN + 1));

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int s_idle_pct   = 0;   // chance in 100 that the sender skips a cycle
    int m_stall_pct  = 0;   // chance in 100 that the receiver stalls a cycle
    int hold_asked   = 0;   // bump to ask the receiver for a long hold-off
    int cycle_count  = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sliding_abs_sum_peak_finder #(
        .MAX_WINDOW (WIN_CAP),
        .MAX_FRAME  (FRAME_CAP)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready)
    );

    sasp_peak_check #(
        .MAX_WINDOW (WIN_CAP),
        .MAX_FRAME  (FRAME_CAP)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls at the current rate, or a long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= m_stall_pct);
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write window_len with junk in the unused upper bits, then read it back.
    task automatic set_window(input int w);
        apb_access(1'b1, WLEN_ADDR, ($urandom() & ~32'h7FF) | (w & 32'h7FF));
        apb_access(1'b0, WLEN_ADDR, '0);
    endtask

    // Offer one sample beat, possibly after idle cycles; return at the accepting edge.
    // Valid stays high into the next call so back-to-back beats need no gap.
    task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic fin);
        while ($urandom_range(99) < s_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= fin;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // A mix of random words, extremes and small magnitudes, the small ones mixed in
    // so that ties between windows come up often.
    function automatic logic [SAMPLE_W-1:0] next_sample();
        logic [SAMPLE_W-1:0] mag;
        mag = SAMPLE_W'($urandom_range(40));
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h8001;
            3:       return 16'h0000;
            4, 5, 6: return $urandom_range(1) ? mag : SAMPLE_W'(~mag + 1'b1);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_beat(next_sample(), i == len - 1);
    endtask

    // Drop valid and let the block drain before touching the register.
    // The extra cycles cover the two-stage pipeline when no result is due.
    task automatic wait_quiet();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Program a window, then stream frames until the item budget is spent.
    // Most frames hold at least one full window; some fall short of it.
    task automatic run_frames(input int wreq, input int budget);
        int w_eff;
        int sent;
        int len;
        set_window(wreq);
        w_eff = (wreq & 32'h7FF) < 1 ? 1 : (wreq & 32'h7FF) > WIN_CAP ? WIN_CAP : wreq & 32'h7FF;
        sent  = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 15)
                len = $urandom_range(w_eff, 1);
            else
                len = w_eff + $urandom_range(w_eff < 16 ? 2 * w_eff + 4 : 8, 0);
            send_frame(len);
            sent += len;
        end
        wait_quiet();
    endtask

    initial begin : stimulus
        int extreme_w;
        int extreme_budget;

        // every input known from time zero
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part, no idling ----
        apb_access(1'b0, WLEN_ADDR, '0);           // reset value reads back as 1
        set_window(1);
        send_beat(16'h8000, 1'b1);                 // most negative sample alone
        send_beat(16'h7FFF, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'h0000, 1'b0);
        send_beat(16'h0001, 1'b1);
        wait_quiet();
        apb_access(1'b1, WLEN_ADDR, 32'hFFFF_F803); // window 3, upper bits must be dropped
        send_beat(16'd100, 1'b0);                  // frame shorter than the window
        send_beat(16'hFF38, 1'b1);
        send_beat(16'd1, 1'b0);                    // equal sums: earlier window wins
        send_beat(16'd2, 1'b0);
        send_beat(16'd3, 1'b0);
        send_beat(16'd3, 1'b0);
        send_beat(16'd2, 1'b0);
        send_beat(16'd1, 1'b1);
        send_beat(16'd1, 1'b0);                    // peak in the window ending on tlast
        send_beat(16'd1, 1'b0);
        send_beat(16'd1, 1'b0);
        send_beat(16'h8000, 1'b1);
        // rewrite the window mid-frame: the open frame keeps length 3
        send_beat(16'd5, 1'b0);
        send_beat(16'd6, 1'b0);
        wait_quiet();
        apb_access(1'b1, WLEN_ADDR, 32'h0000_0000); // zero acts as one from the next frame
        send_beat(16'd7, 1'b1);
        send_beat(16'hFFFD, 1'b0);
        send_beat(16'h8001, 1'b0);
        send_beat(16'd4, 1'b1);
        wait_quiet();
        apb_access(1'b1, SPARE_ADDR, 32'h0000_0005); // outside the map, must be ignored
        apb_access(1'b0, WLEN_ADDR, '0);
        apb_access(1'b1, WLEN_ADDR, 32'h0000_07FF);  // above the cap, acts as the cap
        send_beat(16'h1234, 1'b0);
        send_beat(16'hEDCB, 1'b0);
        send_beat(16'h4000, 1'b1);
        wait_quiet();

        // ---- random part: four idling phases, several window settings each ----
        for (int m = 0; m < 4; m++) begin
            case (m)
                0: begin
                    s_idle_pct = 0;  m_stall_pct = 0;  extreme_w = 2; extreme_budget = 40;
                end
                1: begin
                    s_idle_pct = 83; m_stall_pct = 0;  extreme_w = 0; extreme_budget = 40;
                end
                2: begin
                    s_idle_pct = 0;  m_stall_pct = 83; extreme_w = 1; extreme_budget = 40;
                end
                default: begin
                    s_idle_pct = 8;  m_stall_pct = 8;  extreme_w = 0; extreme_budget = 40;
                end
            endcase
            run_frames($urandom_range(6, 1), 100);
            run_frames($urandom_range(40, 7), 100);
            run_frames(extreme_w, extreme_budget);
        end

        // ---- back-pressure: receiver holds off while short frames keep coming ----
        s_idle_pct  = 0;
        m_stall_pct = 0;
        set_window($urandom_range(2, 1));
        hold_asked++;
        for (int f = 0; f < 40; f++)
            send_frame($urandom_range(2, 1));
        wait_quiet();

        // let any stray result beat show up before the verdict
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hdl/sasp_pkg.sv
hdl/sasp_ram.sv
hdl/sliding_abs_sum_peak_finder.sv
hdl/sasp_chk.sv
verif/sasp_peak_check.sv
verif/sliding_abs_sum_peak_finder_test.sv
